@@ rtl/covariance_matrix_accumulator_unit_assert.svh @@
// Assertion macros for the covariance accumulator top level.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef COVARIANCE_MATRIX_ACCUMULATOR_UNIT_ASSERT_SVH
`define COVARIANCE_MATRIX_ACCUMULATOR_UNIT_ASSERT_SVH

// Condition must hold on every clock edge out of reset.
`define CMA_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define CMA_ASSERT_IMPLIES(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define CMA_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/cma_pkg.sv @@
// Package for the covariance matrix accumulator: sizes, codes, shared types
// and the triangle row-base function. No dependencies.
package cma_pkg;

    localparam int MAX_DIM     = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int ACC_BITS    = 48;

    localparam int IDX_BITS    = $clog2(MAX_DIM);
    localparam int LEN_BITS    = 7;
    localparam int TRI_SIZE    = MAX_DIM * (MAX_DIM + 1) / 2;
    localparam int TRI_BITS    = $clog2(TRI_SIZE);
    localparam int PROD_BITS   = 2 * SAMPLE_BITS;
    localparam int COUNT_BITS  = 16;
    localparam int OUT_BITS    = 48;
    localparam int STATUS_BITS = 2;

    localparam logic [LEN_BITS-1:0]    LEN_RESET = LEN_BITS'(64);
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX = '1;

    localparam logic                   ACTION_PUSH = 1'b0;
    localparam logic                   ACTION_READ = 1'b1;

    localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_SAT   = 2'd2;

    // Push command from the sequencer to the accumulate datapath.
    typedef struct packed {
        logic                          start;
        logic                          fresh;
        logic [IDX_BITS-1:0]           idx;
        logic signed [SAMPLE_BITS-1:0] sample;
    } mac_cmd_t;

    // Datapath status back to the sequencer.
    typedef struct packed {
        logic busy;
        logic sat;
    } mac_stat_t;

    // Address of entry (r,0) in the packed lower triangle: r*(r+1)/2.
    function automatic logic [TRI_BITS-1:0] tri_base(input logic [IDX_BITS-1:0] r);
        logic [IDX_BITS:0]     r1;
        logic [2*IDX_BITS:0]   p;
        r1 = {1'b0, r} + (IDX_BITS+1)'(1);
        p  = (2*IDX_BITS+1)'(r) * (2*IDX_BITS+1)'(r1);
        return TRI_BITS'(p >> 1);
    endfunction

endpackage

@@ rtl/cma_mac.sv @@
// Accumulate datapath: element buffer memory, triangle accumulator memory,
// one multiplier and a saturating read-modify-write pipeline. Uses cma_pkg.
module cma_mac
    import cma_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mac_cmd_t                   cmd,
    input  logic [TRI_BITS-1:0]        rd_addr,
    output logic signed [ACC_BITS-1:0] rd_data,
    output mac_stat_t                  stat
);

    logic signed [SAMPLE_BITS-1:0] buf_mem [MAX_DIM];
    logic signed [ACC_BITS-1:0]    acc_mem [TRI_SIZE];

    logic                          issue_reg;
    logic                          s1_valid_reg;
    logic                          s2_valid_reg;
    logic                          fresh_reg;
    logic [IDX_BITS-1:0]           i_reg;
    logic [IDX_BITS-1:0]           j_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [TRI_BITS-1:0]           base_reg;
    logic [TRI_BITS-1:0]           s1_addr_reg;
    logic [TRI_BITS-1:0]           s2_addr_reg;
    logic signed [SAMPLE_BITS-1:0] buf_q_reg;
    logic signed [ACC_BITS-1:0]    acc_q_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [ACC_BITS-1:0]    acc_hold_reg;

    logic [TRI_BITS-1:0]           acc_raddr;
    logic signed [ACC_BITS:0]      sum;
    logic                          sum_ovf;
    logic signed [ACC_BITS-1:0]    acc_wdata;

    // Share the single accumulator read port between the push sweep and reads.
    assign acc_raddr = issue_reg ? (base_reg + TRI_BITS'(j_reg)) : rd_addr;

    always_comb
    begin
        sum       = {acc_hold_reg[ACC_BITS-1], acc_hold_reg} + (ACC_BITS+1)'(prod_reg);
        sum_ovf   = sum[ACC_BITS] != sum[ACC_BITS-1];
        acc_wdata = sum[ACC_BITS-1:0];
        if (sum_ovf)
        begin
            acc_wdata = sum[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                      : {1'b0, {(ACC_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                issue_reg <= 1'b1;
            end
            else if (issue_reg && j_reg == i_reg)
            begin
                issue_reg <= 1'b0;
            end
            s1_valid_reg <= issue_reg;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            i_reg     <= cmd.idx;
            j_reg     <= '0;
            x_reg     <= cmd.sample;
            fresh_reg <= cmd.fresh;
            base_reg  <= tri_base(cmd.idx);
        end
        else if (issue_reg)
        begin
            j_reg <= j_reg + IDX_BITS'(1);
        end
        s1_addr_reg  <= acc_raddr;
        prod_reg     <= PROD_BITS'(x_reg) * PROD_BITS'(buf_q_reg);
        acc_hold_reg <= fresh_reg ? '0 : acc_q_reg;
        s2_addr_reg  <= s1_addr_reg;
    end

    // Memories: synchronous reads, one write port each.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            buf_mem[cmd.idx] <= cmd.sample;
        end
        buf_q_reg <= buf_mem[j_reg];
        acc_q_reg <= acc_mem[acc_raddr];
        if (s2_valid_reg)
        begin
            acc_mem[s2_addr_reg] <= acc_wdata;
        end
    end

    assign rd_data   = acc_q_reg;
    assign stat.busy = issue_reg | s1_valid_reg | s2_valid_reg;
    assign stat.sat  = s2_valid_reg & sum_ovf;

endmodule

@@ rtl/cma_div.sv @@
// Sequential restoring divider: signed accumulator over unsigned count,
// truncating toward zero, one quotient bit per cycle. Uses cma_pkg.
module cma_div
    import cma_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [ACC_BITS-1:0] dividend,
    input  logic [COUNT_BITS-1:0]      divisor,
    output logic                       busy,
    output logic signed [ACC_BITS-1:0] quotient
);

    localparam int STEP_BITS = $clog2(ACC_BITS);

    logic                   busy_reg;
    logic [STEP_BITS-1:0]   step_reg;
    logic [ACC_BITS-1:0]    mag_reg;
    logic [COUNT_BITS-1:0]  rem_reg;
    logic [COUNT_BITS-1:0]  dvs_reg;
    logic                   neg_reg;

    logic [COUNT_BITS:0]    trial;
    logic                   ge;
    logic [COUNT_BITS-1:0]  rem_next;

    always_comb
    begin
        trial    = {rem_reg, mag_reg[ACC_BITS-1]};
        ge       = trial >= {1'b0, dvs_reg};
        rem_next = ge ? COUNT_BITS'(trial - {1'b0, dvs_reg}) : trial[COUNT_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + STEP_BITS'(1);
            if (step_reg == STEP_BITS'(ACC_BITS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= dividend[ACC_BITS-1] ? ACC_BITS'(-dividend) : ACC_BITS'(dividend);
            neg_reg <= dividend[ACC_BITS-1];
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            mag_reg <= {mag_reg[ACC_BITS-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);

endmodule

@@ rtl/covariance_matrix_accumulator_unit.sv @@
// Top level of the covariance matrix accumulator: handshakes, counters,
// read sequencer and output register. Uses cma_pkg, cma_mac, cma_div and
// the assertion macro header.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   input   | in        | in_valid / in_stall  | action, sample, row, col
//   output  | out       | out_valid / out_stall| entry_value, status
//   config  | in        | cfg_we               | cfg_wdata (vector_length)
//
// A push of element i sweeps row i of the lower triangle through one
// multiplier and the single accumulator memory port; no new beat is taken
// until that sweep drains. A non-empty read is scaled by the bit-serial divider.
// Reset clears control state only; the accumulator memory is never swept.
// A row fill count marks rows not yet touched, which read and add as zero.
// A finished result sits in the output register; new beats are taken while
// it waits, and only a later read blocks until that register frees up.
module covariance_matrix_accumulator_unit
    import cma_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          action,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic [IDX_BITS-1:0]           row,
    input  logic [IDX_BITS-1:0]           col,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [OUT_BITS-1:0]    entry_value,
    output logic [STATUS_BITS-1:0]        status,
    // configuration
    input  logic                          cfg_we,
    input  logic [LEN_BITS-1:0]           cfg_wdata
);

`include "covariance_matrix_accumulator_unit_assert.svh"

    // Read sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic [LEN_BITS-1:0]        vector_length_reg;
    logic [IDX_BITS-1:0]        element_index_reg;
    logic [COUNT_BITS-1:0]      vector_count_reg;
    logic                       overflow_seen_reg;
    logic [IDX_BITS:0]          rows_touched_reg;
    logic                       rd_zero_reg;
    logic                       empty_reg;
    logic                       out_valid_reg;
    logic signed [OUT_BITS-1:0] entry_value_reg;
    logic [STATUS_BITS-1:0]     status_reg;

    logic [LEN_BITS-1:0]        len_eff;
    logic                       accept;
    logic                       push;
    logic                       rd_req;
    logic                       last_elem;
    logic [IDX_BITS-1:0]        r_hi;
    logic [IDX_BITS-1:0]        c_lo;
    logic [TRI_BITS-1:0]        rd_addr;
    logic                       out_free;

    mac_cmd_t                   mac_cmd;
    mac_stat_t                  mac_stat;
    logic signed [ACC_BITS-1:0] mac_rd_data;

    logic                       div_start;
    logic                       div_busy;
    logic signed [ACC_BITS-1:0] div_dividend;
    logic signed [ACC_BITS-1:0] div_quotient;

    // Clamp the programmed length into 1..MAX_DIM.
    always_comb
    begin
        len_eff = vector_length_reg;
        if (vector_length_reg == '0)
        begin
            len_eff = LEN_BITS'(1);
        end
        else if (vector_length_reg > LEN_BITS'(MAX_DIM))
        begin
            len_eff = LEN_BITS'(MAX_DIM);
        end
    end

    // Take a beat only with the sequencer idle and the row sweep drained.
    assign in_stall  = (state_reg != S_IDLE) || mac_stat.busy;
    assign accept    = in_valid && !in_stall;
    assign push      = accept && (action == ACTION_PUSH);
    assign rd_req    = accept && (action == ACTION_READ);
    assign last_elem = (LEN_BITS'(element_index_reg) + LEN_BITS'(1)) >= len_eff;

    always_comb
    begin
        mac_cmd.start  = push;
        mac_cmd.fresh  = {1'b0, element_index_reg} >= rows_touched_reg;
        mac_cmd.idx    = element_index_reg;
        mac_cmd.sample = sample;
    end

    // Mirror upper-triangle requests into the stored lower triangle.
    always_comb
    begin
        r_hi = row;
        c_lo = col;
        if (col > row)
        begin
            r_hi = col;
            c_lo = row;
        end
        rd_addr = tri_base(r_hi) + TRI_BITS'(c_lo);
    end

    cma_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mac_cmd),
        .rd_addr (rd_addr),
        .rd_data (mac_rd_data),
        .stat    (mac_stat)
    );

    assign div_start    = (state_reg == S_LOAD) && !empty_reg;
    assign div_dividend = rd_zero_reg ? '0 : mac_rd_data;

    cma_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (vector_count_reg),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (rd_req)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = empty_reg ? S_HOLD : S_DIV;
            end
            S_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            vector_length_reg <= LEN_RESET;
            element_index_reg <= '0;
            vector_count_reg  <= '0;
            overflow_seen_reg <= 1'b0;
            rows_touched_reg  <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                vector_length_reg <= cfg_wdata;
            end

            // Advance the element index; wrap and count on the last element.
            if (push)
            begin
                if (mac_cmd.fresh)
                begin
                    rows_touched_reg <= {1'b0, element_index_reg} + (IDX_BITS+1)'(1);
                end
                if (last_elem)
                begin
                    element_index_reg <= '0;
                    if (vector_count_reg != COUNT_MAX)
                    begin
                        vector_count_reg <= vector_count_reg + COUNT_BITS'(1);
                    end
                end
                else
                begin
                    element_index_reg <= element_index_reg + IDX_BITS'(1);
                end
            end

            if (mac_stat.sat)
            begin
                overflow_seen_reg <= 1'b1;
            end

            if (state_reg == S_HOLD && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Read context and result payload.
    always_ff @(posedge clk)
    begin
        if (rd_req)
        begin
            rd_zero_reg <= {1'b0, r_hi} >= rows_touched_reg;
            empty_reg   <= vector_count_reg == '0;
        end
        if (state_reg == S_HOLD && out_free)
        begin
            if (empty_reg)
            begin
                entry_value_reg <= '0;
                status_reg      <= STATUS_EMPTY;
            end
            else
            begin
                entry_value_reg <= OUT_BITS'(div_quotient);
                status_reg      <= overflow_seen_reg ? STATUS_SAT : STATUS_OK;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign entry_value = entry_value_reg;
    assign status      = status_reg;

    `CMA_ASSERT_IMPLIES(a_seq_excl_sweep, state_reg != S_IDLE, !mac_stat.busy, "read overlaps row sweep")
    `CMA_ASSERT_IMPLIES(a_div_in_div_state, div_busy, state_reg == S_DIV, "divider busy outside divide state")
    `CMA_ASSERT_HOLDS(a_rows_bound, rows_touched_reg <= (IDX_BITS+1)'(MAX_DIM), "row fill count past matrix side")
    `CMA_ASSERT_NEXT(a_ovf_sticky, overflow_seen_reg, overflow_seen_reg, "overflow flag cleared")
    `CMA_ASSERT_NEXT(a_hold_loads, state_reg == S_HOLD && out_free, out_valid_reg, "result not presented")

endmodule
